### sv/wsfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfp_pkg
// Shared types and constants of the WebSocket frame parser.
// ----------------------------------------------------------------------------
package wsfp_pkg;

	localparam int LEN_W = 64;
	localparam int OUT_LEN_W = 63;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam logic [2:0] EXT16_CNT = 3'd1;
	localparam logic [2:0] EXT64_CNT = 3'd7;
	localparam logic [2:0] KEY_CNT   = 3'd3;

	localparam logic KIND_HDR  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} stage_t;

	typedef struct packed {
		logic                 kind;
		logic                 fin;
		logic [3:0]           opcode;
		logic                 masked;
		logic [OUT_LEN_W-1:0] payload_length;
		logic [7:0]           data_byte;
		logic                 last;
	} result_t;

endpackage

### sv/wsfp_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfp_byte_if
// Request channel carrying one raw frame byte.
// ----------------------------------------------------------------------------
interface wsfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

### sv/wsfp_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfp_result_if
// Request channel carrying one header or payload result.
// ----------------------------------------------------------------------------
interface wsfp_result_if;
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic                            fin;
	logic [3:0]                      opcode;
	logic                            masked;
	logic [wsfp_pkg::OUT_LEN_W-1:0]  payload_length;
	logic [7:0]                      data_byte;
	logic                            last;

	modport source (output valid, output kind, output fin, output opcode, output masked,
		output payload_length, output data_byte, output last, input ready);
	modport sink (input valid, input kind, input fin, input opcode, input masked,
		input payload_length, input data_byte, input last, output ready);
endinterface

### sv/wsfp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfp_in_reg
// Input register stage; refills in the same cycle the held byte is taken.
// ----------------------------------------------------------------------------
module wsfp_in_reg (
	input  logic             clk,
	input  logic             arst_n,
	wsfp_byte_if.sink        frame,
	input  logic             take,
	output wsfp_pkg::stage_t item
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	assign frame.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			byte_s1 <= frame.in_byte;
		end
	end

	assign item.valid = valid_s1;
	assign item.data  = byte_s1;

endmodule

### sv/wsfp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfp_parse
// Frame header state machine, payload unmasking and result formation.
// ----------------------------------------------------------------------------
module wsfp_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  wsfp_pkg::stage_t  item,
	input  logic              space,
	output logic              take,
	output logic              emit,
	output wsfp_pkg::result_t res
);

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_EXT  = 3'd2,
		PH_KEY  = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	phase_t                         phase_q, phase_d;
	logic                           fin_q, fin_d;
	logic [3:0]                     opcode_q, opcode_d;
	logic                           mask_q, mask_d;
	logic [wsfp_pkg::LEN_W-1:0]     len_q, len_d;
	logic [2:0]                     cnt_q, cnt_d;
	logic [31:0]                    key_q, key_d;
	logic [wsfp_pkg::LEN_W-1:0]     pc_q, pc_d;
	logic                           len_done;
	logic                           hdr_done;
	logic                           hit;
	logic                           kind;
	logic                           last;
	logic [7:0]                     key_byte;
	logic [7:0]                     data;
	logic [7:0]                     b;

	assign b    = item.data;
	assign take = item.valid && space;

	always_comb begin
		case (pc_q[1:0])
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		fin_d    = fin_q;
		opcode_d = opcode_q;
		mask_d   = mask_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		key_d    = key_q;
		pc_d     = pc_q;
		len_done = 1'b0;
		hdr_done = 1'b0;
		hit      = 1'b0;
		kind     = wsfp_pkg::KIND_HDR;
		last     = 1'b0;
		data     = 8'd0;
		unique case (phase_q)
			PH_HDR1: begin
				mask_d = b[7];
				if (b[6:0] == wsfp_pkg::LEN_EXT16) begin
					len_d   = '0;
					cnt_d   = wsfp_pkg::EXT16_CNT;
					phase_d = PH_EXT;
				end else if (b[6:0] == wsfp_pkg::LEN_EXT64) begin
					len_d   = '0;
					cnt_d   = wsfp_pkg::EXT64_CNT;
					phase_d = PH_EXT;
				end else begin
					len_d    = {{(wsfp_pkg::LEN_W-7){1'b0}}, b[6:0]};
					len_done = 1'b1;
				end
			end
			PH_EXT: begin
				len_d = {len_q[wsfp_pkg::LEN_W-9:0], b};
				if (cnt_q == 3'd0) begin
					len_done = 1'b1;
				end else begin
					cnt_d = cnt_q - 3'd1;
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], b};
				if (cnt_q == 3'd0) begin
					hdr_done = 1'b1;
				end else begin
					cnt_d = cnt_q - 3'd1;
				end
			end
			PH_DATA: begin
				data = mask_q ? (b ^ key_byte) : b;
				pc_d = pc_q + {{(wsfp_pkg::LEN_W-1){1'b0}}, 1'b1};
				last = (pc_d >= len_q);
				kind = wsfp_pkg::KIND_DATA;
				hit  = 1'b1;
				if (last) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				fin_d    = b[7];
				opcode_d = b[3:0];
				phase_d  = PH_HDR1;
			end
		endcase
		if (len_done) begin
			len_d[wsfp_pkg::LEN_W-1] = 1'b0;
			if (mask_d) begin
				cnt_d   = wsfp_pkg::KEY_CNT;
				key_d   = '0;
				phase_d = PH_KEY;
			end else begin
				hdr_done = 1'b1;
			end
		end
		if (hdr_done) begin
			pc_d    = '0;
			hit     = 1'b1;
			last    = (len_d == '0);
			phase_d = last ? PH_HDR0 : PH_DATA;
		end
	end

	assign emit = take && hit;

	assign res.kind           = kind;
	assign res.fin            = fin_d;
	assign res.opcode         = opcode_d;
	assign res.masked         = mask_d;
	assign res.payload_length = len_d[wsfp_pkg::OUT_LEN_W-1:0];
	assign res.data_byte      = data;
	assign res.last           = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			fin_q    <= 1'b0;
			opcode_q <= 4'd0;
			mask_q   <= 1'b0;
			len_q    <= '0;
			cnt_q    <= 3'd0;
			key_q    <= '0;
			pc_q     <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			opcode_q <= opcode_d;
			mask_q   <= mask_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			key_q    <= key_d;
			pc_q     <= pc_d;
		end
	end

	a_data_emits: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == PH_DATA |-> emit && res.kind == wsfp_pkg::KIND_DATA)
		else $error("payload byte taken without a payload result");

	a_hdr0_silent: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == PH_HDR0 |-> !emit)
		else $error("result emitted on first header byte");

	a_last_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res.last |=> phase_q == PH_HDR0)
		else $error("parser not rearmed after last result");

	a_key_masked: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_KEY |-> mask_q)
		else $error("key phase entered without mask bit");

endmodule

### sv/wsfp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfp_out_reg
// Result register; reports space when empty or being drained this cycle.
// ----------------------------------------------------------------------------
module wsfp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  wsfp_pkg::result_t res,
	output logic              space,
	wsfp_result_if.source     result
);

	logic              valid_q;
	wsfp_pkg::result_t res_q;

	assign space = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign result.valid          = valid_q;
	assign result.kind           = res_q.kind;
	assign result.fin            = res_q.fin;
	assign result.opcode         = res_q.opcode;
	assign result.masked         = res_q.masked;
	assign result.payload_length = res_q.payload_length;
	assign result.data_byte      = res_q.data_byte;
	assign result.last           = res_q.last;

endmodule

### sv/websocket_frame_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_parser_top
// Byte-serial WebSocket frame parser: header results and unmasked payload.
// Bytes pass the input register, the parse logic and the result register.
// Throughput: one byte per cycle while result.ready is high (single parse stage).
// Only the last header byte produces a result, the header result.
// Reset clears valid flags and parse state; the parser waits for a frame start.
// ----------------------------------------------------------------------------
module websocket_frame_parser_top (
	input  logic          clk,
	input  logic          arst_n,
	wsfp_byte_if.sink     frame,
	wsfp_result_if.source result
);

	wsfp_pkg::stage_t  item;
	wsfp_pkg::result_t res;
	logic              take;
	logic              emit;
	logic              space;

	wsfp_in_reg u_in_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame),
		.take   (take),
		.item   (item)
	);

	wsfp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.space  (space),
		.take   (take),
		.emit   (emit),
		.res    (res)
	);

	wsfp_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit),
		.res    (res),
		.space  (space),
		.result (result)
	);

endmodule

### tb/websocket_frame_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_parser_checker
// Watches both channels of the frame parser. Every accepted byte request goes
// through a bit-accurate parse of the frame header and payload. Each expected
// header or payload result is queued and compared field by field with the
// next accepted result request.
// ----------------------------------------------------------------------------
module websocket_frame_parser_checker
	import wsfp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	wsfp_byte_if   frame,
	wsfp_result_if result,
	output int     fail_count,
	output int     expected_left
);

	typedef enum logic [2:0] {
		ST_HDR0 = 3'd0,
		ST_HDR1 = 3'd1,
		ST_EXT  = 3'd2,
		ST_KEY  = 3'd3,
		ST_DATA = 3'd4
	} parse_st_t;

	parse_st_t         st;
	logic              fin_q;
	logic [3:0]        op_q;
	logic              mask_q;
	logic [LEN_W-1:0]  len_q;
	logic [2:0]        cnt_q;
	logic [31:0]       key_q;
	logic [LEN_W-1:0]  pcnt_q;

	result_t           frame_results_q[$];

	function automatic result_t make_result(input logic kind, input logic [7:0] data,
		input logic last);
		result_t r;
		r.kind           = kind;
		r.fin            = fin_q;
		r.opcode         = op_q;
		r.masked         = mask_q;
		r.payload_length = len_q[OUT_LEN_W-1:0];
		r.data_byte      = data;
		r.last           = last;
		return r;
	endfunction

	task automatic header_done(output logic emit, output result_t r);
		logic empty;
		empty  = (len_q == '0);
		pcnt_q = '0;
		r      = make_result(KIND_HDR, 8'h00, empty);
		emit   = 1'b1;
		st     = empty ? ST_HDR0 : ST_DATA;
	endtask

	task automatic close_length(output logic emit, output result_t r);
		len_q[LEN_W-1] = 1'b0;
		if (mask_q) begin
			cnt_q = KEY_CNT;
			key_q = '0;
			st    = ST_KEY;
			emit  = 1'b0;
			r     = '0;
		end else begin
			header_done(emit, r);
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, output logic emit, output result_t r);
		logic [7:0] data;
		logic       last;
		emit = 1'b0;
		r    = '0;
		case (st)
			ST_HDR1: begin
				mask_q = b[7];
				if (b[6:0] == LEN_EXT16) begin
					len_q = '0;
					cnt_q = EXT16_CNT;
					st    = ST_EXT;
				end else if (b[6:0] == LEN_EXT64) begin
					len_q = '0;
					cnt_q = EXT64_CNT;
					st    = ST_EXT;
				end else begin
					len_q = {57'd0, b[6:0]};
					close_length(emit, r);
				end
			end
			ST_EXT: begin
				len_q = {len_q[LEN_W-9:0], b};
				if (cnt_q == 3'd0) close_length(emit, r);
				else cnt_q = cnt_q - 3'd1;
			end
			ST_KEY: begin
				key_q = {key_q[23:0], b};
				if (cnt_q == 3'd0) header_done(emit, r);
				else cnt_q = cnt_q - 3'd1;
			end
			ST_DATA: begin
				data = mask_q ? (b ^ key_q[24 - 8 * pcnt_q[1:0] +: 8]) : b;
				pcnt_q = pcnt_q + 64'd1;
				last = (pcnt_q >= len_q);
				r    = make_result(KIND_DATA, data, last);
				emit = 1'b1;
				if (last) st = ST_HDR0;
			end
			default: begin
				fin_q = b[7];
				op_q  = b[3:0];
				st    = ST_HDR1;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t exp_r;
		result_t got;
		logic    emit;
		if (!arst_n) begin
			st     = ST_HDR0;
			fin_q  = 1'b0;
			op_q   = '0;
			mask_q = 1'b0;
			len_q  = '0;
			cnt_q  = '0;
			key_q  = '0;
			pcnt_q = '0;
			frame_results_q.delete();
			fail_count    = 0;
			expected_left = 0;
		end else begin
			if (result.valid && result.ready) begin
				got.kind           = result.kind;
				got.fin            = result.fin;
				got.opcode         = result.opcode;
				got.masked         = result.masked;
				got.payload_length = result.payload_length;
				got.data_byte      = result.data_byte;
				got.last           = result.last;
				if (frame_results_q.size() == 0) begin
					$error("result request with no expected result pending");
					fail_count++;
				end else begin
					exp_r = frame_results_q.pop_front();
					if (got.kind !== exp_r.kind) begin
						$error("kind: expected %0h, actual %0h", exp_r.kind, got.kind);
						fail_count++;
					end
					if (got.fin !== exp_r.fin) begin
						$error("fin: expected %0h, actual %0h", exp_r.fin, got.fin);
						fail_count++;
					end
					if (got.opcode !== exp_r.opcode) begin
						$error("opcode: expected %0h, actual %0h", exp_r.opcode, got.opcode);
						fail_count++;
					end
					if (got.masked !== exp_r.masked) begin
						$error("masked: expected %0h, actual %0h", exp_r.masked, got.masked);
						fail_count++;
					end
					if (got.payload_length !== exp_r.payload_length) begin
						$error("payload_length: expected %0h, actual %0h",
							exp_r.payload_length, got.payload_length);
						fail_count++;
					end
					if (got.data_byte !== exp_r.data_byte) begin
						$error("data_byte: expected %0h, actual %0h",
							exp_r.data_byte, got.data_byte);
						fail_count++;
					end
					if (got.last !== exp_r.last) begin
						$error("last: expected %0h, actual %0h", exp_r.last, got.last);
						fail_count++;
					end
				end
			end
			if (frame.valid && frame.ready) begin
				parse_byte(frame.in_byte, emit, exp_r);
				if (emit) frame_results_q.push_back(exp_r);
			end
			expected_left = frame_results_q.size();
		end
	end

endmodule

### tb/websocket_frame_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_parser_top_tb
// Drives byte-serial WebSocket frames into the parser: a few directed frames
// for zero length, masking, extended and oversized lengths, then random
// frames under changing idle patterns and a long result stall. A checker
// instance predicts and compares every result; the verdict is given here.
// ----------------------------------------------------------------------------
module websocket_frame_parser_top_tb;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   expected_left;
	int   tx_idle_pct;
	int   rx_idle_pct;
	bit   hold_req;
	bit   hold_done;
	int   bytes_sent;

	wsfp_byte_if   frame_ch ();
	wsfp_result_if result_ch ();

	websocket_frame_parser_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch)
	);

	websocket_frame_parser_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame         (frame_ch),
		.result        (result_ch),
		.fail_count    (fail_count),
		.expected_left (expected_left)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("websocket_frame_parser_top_tb: errors");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		hold_done       = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				result_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_done = 1'b1;
			end
			result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			frame_ch.valid <= 1'b0;
			@(posedge clk);
		end
		frame_ch.valid   <= 1'b1;
		frame_ch.in_byte <= b;
		do @(posedge clk); while (!frame_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] hdr0, input logic mask, input logic [6:0] len7,
		input logic [63:0] ext, input int cap);
		logic [63:0] body_len;
		send_byte(hdr0);
		send_byte({mask, len7});
		if (len7 == wsfp_pkg::LEN_EXT16) begin
			send_byte(ext[15:8]);
			send_byte(ext[7:0]);
			body_len = {48'd0, ext[15:0]};
		end else if (len7 == wsfp_pkg::LEN_EXT64) begin
			for (int i = 7; i >= 0; i--) send_byte(ext[8 * i +: 8]);
			body_len = {1'b0, ext[62:0]};
		end else begin
			body_len = {57'd0, len7};
		end
		if (mask) repeat (4) send_byte(8'($urandom));
		if (body_len > 64'(cap)) body_len = 64'(cap);
		for (longint unsigned i = 0; i < body_len; i++) send_byte(8'($urandom));
	endtask

	task automatic run_random(input int n_bytes);
		int          stop_at;
		int          pick;
		logic [6:0]  len7;
		logic [63:0] ext;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			ext  = {64{1'b0}};
			if (pick < 70) begin
				len7 = 7'($urandom_range(0, 16));
			end else if (pick < 80) begin
				len7 = 7'($urandom_range(17, 125));
			end else if (pick < 92) begin
				len7 = wsfp_pkg::LEN_EXT16;
				ext[15:0] = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 400))
					: 16'($urandom_range(0, 40));
			end else begin
				len7 = wsfp_pkg::LEN_EXT64;
				ext  = {1'($urandom), 47'd0, 16'($urandom_range(0, 30))};
			end
			send_frame(8'($urandom), 1'($urandom), len7, ext, 1000);
		end
	endtask

	task automatic drain();
		frame_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0) @(posedge clk);
	endtask

	initial begin
		arst_n           = 1'b0;
		frame_ch.valid   = 1'b0;
		frame_ch.in_byte = 8'h00;
		tx_idle_pct      = 37;
		rx_idle_pct      = 48;
		hold_req         = 1'b0;
		bytes_sent       = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero length, masked short, non-minimal 16-bit, 64-bit with top bit set
		send_frame(8'h8F, 1'b0, 7'd0, 64'd0, 1000);
		send_frame(8'h01, 1'b1, 7'd2, 64'd0, 1000);
		send_frame(8'h70, 1'b0, wsfp_pkg::LEN_EXT16, 64'd1, 1000);
		send_frame(8'hF0, 1'b0, wsfp_pkg::LEN_EXT64, 64'h8000_0000_0000_0001, 1000);
		drain();

		run_random(570);
		drain();

		tx_idle_pct = 48;
		rx_idle_pct = 37;
		run_random(570);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req    = 1'b1;
		run_random(570);

		// oversized length: stream ends inside the payload
		send_frame(8'h8A, 1'b1, wsfp_pkg::LEN_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 6);
		drain();
		repeat (8) @(posedge clk);

		if (fail_count == 0 && expected_left == 0) begin
			$display("websocket_frame_parser_top_tb: clean");
		end else begin
			$display("websocket_frame_parser_top_tb: errors");
		end
		$finish;
	end

endmodule
